@@ rtl/hsfd_pkg.sv @@
// Shared types, constants and functions for the measurement frame decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

  // CRC-8 over each three-byte group, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within a frame
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // Conversion constants (hundredths)
  localparam logic [14:0] TEMP_SPAN  = 15'd17500;
  localparam logic [14:0] HUM_SPAN   = 15'd12500;
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  localparam logic signed [15:0] TEMP_OFFS = 16'sd4500;
  localparam logic signed [15:0] HUM_OFFS  = 16'sd600;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One checked frame, handed from front to back
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_humid;
    logic        temp_ok;
    logic        humid_ok;
  } frame_rec_t;

  // Queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // One byte of CRC-8, bitwise MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 2^31: q0 = x>>16 and remainder (x & 0xFFFF) + q0,
  // which stays below twice the divisor, so one compare fixes the quotient
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return (r >= {1'b0, FULL_SCALE}) ? q0 + 15'd1 : q0;
  endfunction

endpackage

`default_nettype wire

@@ rtl/humidity_sensor_frame_decoder_top.sv @@
// Top level of the measurement frame decoder: front end, queue, back end.
// Depends on hsfd_pkg, hsfd_front, hsfd_fifo, hsfd_back.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_ready  | rx_byte, frame_start
//   out     | out_valid / out_ready| raw_temp, raw_humid, temp_crc_ok,
//           |                      | humid_crc_ok, temp_centi, humid_centi
//
// One byte is taken per cycle while in_ready is high; the sixth frame byte's
// record passes queue, multiply stage, divide and offset stage to out_valid.
// in_ready drops only when the queue is full, i.e. when results back up.
// Reset clears frame position, CRC, queue count and pipeline valid bits.
// A stalled output holds its result while the front keeps taking bytes.
`timescale 1ns / 1ps
`default_nettype none

module humidity_sensor_frame_decoder_top #(
  parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               frame_start,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             raw_temp,
  output logic [15:0]             raw_humid,
  output logic                    temp_crc_ok,
  output logic                    humid_crc_ok,
  output logic signed [14:0]      temp_centi,
  output logic signed [14:0]      humid_centi
);

  hsfd_pkg::queue_stat_t q_stat;
  hsfd_pkg::frame_rec_t  push_data;
  hsfd_pkg::frame_rec_t  pop_data;
  logic                  q_push;
  logic                  q_pop;

  hsfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  hsfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (pop_data),
    .stat    (q_stat)
  );

  hsfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_temp     (raw_temp),
    .raw_humid    (raw_humid),
    .temp_crc_ok  (temp_crc_ok),
    .humid_crc_ok (humid_crc_ok),
    .temp_centi   (temp_centi),
    .humid_centi  (humid_centi)
  );

endmodule

`default_nettype wire

@@ rtl/hsfd_fifo.sv @@
// Short register queue carrying checked frames from the front to the back.
// Depends on hsfd_pkg (frame_rec_t, queue_stat_t).
`timescale 1ns / 1ps
`default_nettype none

module hsfd_fifo #(
  parameter int DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire hsfd_pkg::frame_rec_t wr_data,
  input  wire logic               pop,
  output hsfd_pkg::frame_rec_t    rd_data,
  output hsfd_pkg::queue_stat_t   stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  hsfd_pkg::frame_rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count missed a push");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push && count == CNT_W'(1)) |=> stat.empty)
    else $error("queue not empty after last pop");

endmodule

`default_nettype wire

@@ rtl/hsfd_front.sv @@
// Front end: accepts frame bytes, tracks position, runs the group CRCs and
// assembles the raw words; pushes one record per completed frame.
// Depends on hsfd_pkg (crc8_byte, position codes, frame_rec_t, queue_stat_t).
`timescale 1ns / 1ps
`default_nettype none

module hsfd_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  frame_start,
  input  wire hsfd_pkg::queue_stat_t q_stat,
  output logic                       q_push,
  output hsfd_pkg::frame_rec_t       q_data
);

  logic [2:0]  byte_position;
  logic [7:0]  crc_register;
  logic [15:0] temp_word;
  logic [15:0] humid_word;
  logic        temp_group_good;

  logic [2:0]  pos;
  logic [7:0]  crc_base;
  logic [7:0]  crc_new;
  logic        xfer;

  // A byte is taken whenever a completed frame would find room in the queue
  assign in_ready = !q_stat.full;
  assign xfer     = in_valid && in_ready;

  // Effective position: frame start or a stray value restarts the frame
  always_comb begin
    if (frame_start || byte_position > hsfd_pkg::POS_HUM_CRC) begin
      pos = hsfd_pkg::POS_TEMP_HI;
    end else begin
      pos = byte_position;
    end
    if (pos == hsfd_pkg::POS_TEMP_HI || pos == hsfd_pkg::POS_HUM_HI) begin
      crc_base = hsfd_pkg::CRC_INIT;
    end else begin
      crc_base = crc_register;
    end
    crc_new = hsfd_pkg::crc8_byte(crc_base, rx_byte);
  end

  // Record push on the last byte of a frame
  assign q_push           = xfer && (pos == hsfd_pkg::POS_HUM_CRC);
  assign q_data.raw_temp  = temp_word;
  assign q_data.raw_humid = humid_word;
  assign q_data.temp_ok   = temp_group_good;
  assign q_data.humid_ok  = (crc_new == 8'h00);

  // Position and running CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= hsfd_pkg::POS_TEMP_HI;
      crc_register  <= hsfd_pkg::CRC_INIT;
    end else if (xfer) begin
      if (pos == hsfd_pkg::POS_HUM_CRC) begin
        byte_position <= hsfd_pkg::POS_TEMP_HI;
        crc_register  <= hsfd_pkg::CRC_INIT;
      end else begin
        byte_position <= pos + 3'd1;
        crc_register  <= crc_new;
      end
    end
  end

  // Word assembly and temperature check flag
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_word       <= '0;
      humid_word      <= '0;
      temp_group_good <= 1'b0;
    end else if (xfer) begin
      unique case (pos)
        hsfd_pkg::POS_TEMP_HI:  temp_word       <= {rx_byte, 8'h00};
        hsfd_pkg::POS_TEMP_LO:  temp_word       <= {temp_word[15:8], rx_byte};
        hsfd_pkg::POS_TEMP_CRC: temp_group_good <= (crc_new == 8'h00);
        hsfd_pkg::POS_HUM_HI:   humid_word      <= {rx_byte, 8'h00};
        hsfd_pkg::POS_HUM_LO:   humid_word      <= {humid_word[15:8], rx_byte};
        default: ;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= hsfd_pkg::POS_HUM_CRC)
    else $error("byte position out of frame");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("frame pushed into full queue");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (xfer && frame_start) |=> (byte_position == hsfd_pkg::POS_TEMP_LO))
    else $error("frame start did not restart position");

endmodule

`default_nettype wire

@@ rtl/hsfd_back.sv @@
// Back end: scales the raw words to hundredths in a two-stage pipeline
// (multiply, then divide by full scale and offset) and holds the result.
// Depends on hsfd_pkg (div_full_scale, span and offset constants, frame_rec_t).
`timescale 1ns / 1ps
`default_nettype none

module hsfd_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hsfd_pkg::queue_stat_t q_stat,
  input  wire hsfd_pkg::frame_rec_t  q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                raw_temp,
  output logic [15:0]                raw_humid,
  output logic                       temp_crc_ok,
  output logic                       humid_crc_ok,
  output logic signed [14:0]         temp_centi,
  output logic signed [14:0]         humid_centi
);

  logic                 s1_valid;
  hsfd_pkg::frame_rec_t s1_rec;
  logic [30:0]          s1_temp_prod;
  logic [30:0]          s1_humid_prod;
  logic                 s2_load;
  logic                 s1_load;
  logic signed [15:0]   temp_full;
  logic signed [15:0]   humid_full;

  assign s2_load = s1_valid && (!out_valid || out_ready);
  assign s1_load = !s1_valid || s2_load;
  assign q_pop   = s1_load && !q_stat.empty;

  // Stage 1: products of raw word and span
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_rec        <= q_data;
      s1_temp_prod  <= 31'(q_data.raw_temp) * 31'(hsfd_pkg::TEMP_SPAN);
      s1_humid_prod <= 31'(q_data.raw_humid) * 31'(hsfd_pkg::HUM_SPAN);
    end
  end

  // Stage 2: divide by full scale, remove offset
  always_comb begin
    temp_full  = $signed({1'b0, hsfd_pkg::div_full_scale(s1_temp_prod)})
                 - hsfd_pkg::TEMP_OFFS;
    humid_full = $signed({1'b0, hsfd_pkg::div_full_scale(s1_humid_prod)})
                 - hsfd_pkg::HUM_OFFS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      raw_temp     <= s1_rec.raw_temp;
      raw_humid    <= s1_rec.raw_humid;
      temp_crc_ok  <= s1_rec.temp_ok;
      humid_crc_ok <= s1_rec.humid_ok;
      temp_centi   <= temp_full[14:0];
      humid_centi  <= humid_full[14:0];
    end
  end

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temp_centi >= -15'sd4500 && temp_centi <= 15'sd13000))
    else $error("temperature out of range");

  a_humid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (humid_centi >= -15'sd600 && humid_centi <= 15'sd11900))
    else $error("humidity out of range");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("stage 1 item lost while output stalled");

endmodule

`default_nettype wire

@@ tb/sv/tb_humidity_sensor_frame_decoder_top.sv @@
// Self-checking testbench for humidity_sensor_frame_decoder_top.
// Depends on hsfd_pkg and the decoder RTL; predicts CRC flags and conversions per frame.
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decoder_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 125;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // One frame byte as offered to the block
  typedef struct {
    logic [7:0] data;
    logic       start;
  } frame_byte_t;

  // One decoded measurement
  typedef struct {
    logic [15:0]        raw_temp;
    logic [15:0]        raw_humid;
    logic               temp_ok;
    logic               humid_ok;
    logic signed [14:0] temp_centi;
    logic signed [14:0] humid_centi;
  } measurement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        raw_temp;
  logic [15:0]        raw_humid;
  logic               temp_crc_ok;
  logic               humid_crc_ok;
  logic signed [14:0] temp_centi;
  logic signed [14:0] humid_centi;

  frame_byte_t  byte_queue[$];
  measurement_t meas_queue[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int mismatch_count  = 0;
  int quiet_cycles    = 0;

  // Shadow of the decoder's frame state
  logic [2:0]  shadow_pos   = 3'd0;
  logic [7:0]  shadow_crc   = hsfd_pkg::CRC_INIT;
  logic [15:0] shadow_temp  = 16'h0000;
  logic [15:0] shadow_humid = 16'h0000;
  logic        shadow_tgood = 1'b0;

  humidity_sensor_frame_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_temp     (raw_temp),
    .raw_humid    (raw_humid),
    .temp_crc_ok  (temp_crc_ok),
    .humid_crc_ok (humid_crc_ok),
    .temp_centi   (temp_centi),
    .humid_centi  (humid_centi)
  );

  // CRC-8 shifted one data bit at a time, MSB first
  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0} ^ (fb ? hsfd_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // floor(span * word / 65535) - offset, kept to 15 bits
  function automatic logic signed [14:0] scale_centi(input logic [15:0] word,
                                                     input int unsigned span,
                                                     input int offset);
    int unsigned scaled;
    int          v;
    scaled = (span * {16'd0, word}) / 32'd65535;
    v = int'(scaled) - offset;
    return v[14:0];
  endfunction

  // Advance the shadow state by one byte; a result comes out on the sixth byte
  task automatic decode_frame_byte(input logic [7:0] data, input logic start,
                                   output bit done, output measurement_t meas);
    logic [2:0] pos;
    logic [7:0] c;
    done = 1'b0;
    meas = '{default: '0};
    if (start) begin
      shadow_pos = 3'd0;
      shadow_crc = hsfd_pkg::CRC_INIT;
    end
    pos = shadow_pos;
    if (pos > hsfd_pkg::POS_HUM_CRC) pos = hsfd_pkg::POS_TEMP_HI;
    if (pos == hsfd_pkg::POS_TEMP_HI || pos == hsfd_pkg::POS_HUM_HI)
      shadow_crc = hsfd_pkg::CRC_INIT;
    c = crc8_shift(shadow_crc, data);
    case (pos)
      hsfd_pkg::POS_TEMP_HI:  shadow_temp  = {data, 8'h00};
      hsfd_pkg::POS_TEMP_LO:  shadow_temp  = {shadow_temp[15:8], data};
      hsfd_pkg::POS_TEMP_CRC: shadow_tgood = (c == 8'h00);
      hsfd_pkg::POS_HUM_HI:   shadow_humid = {data, 8'h00};
      hsfd_pkg::POS_HUM_LO:   shadow_humid = {shadow_humid[15:8], data};
      default: ;
    endcase
    if (pos == hsfd_pkg::POS_HUM_CRC) begin
      done             = 1'b1;
      meas.raw_temp    = shadow_temp;
      meas.raw_humid   = shadow_humid;
      meas.temp_ok     = shadow_tgood;
      meas.humid_ok    = (c == 8'h00);
      meas.temp_centi  = scale_centi(shadow_temp, 17500, 4500);
      meas.humid_centi = scale_centi(shadow_humid, 12500, 600);
      shadow_pos       = 3'd0;
      shadow_crc       = hsfd_pkg::CRC_INIT;
    end else begin
      shadow_crc = c;
      shadow_pos = pos + 3'd1;
    end
  endtask

  // Queue one six-byte frame; a bad group gets a corrupted check byte
  task automatic push_frame(input logic [15:0] t, input logic [15:0] h,
                            input bit t_bad, input bit h_bad, input logic marker);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = crc8_shift(crc8_shift(hsfd_pkg::CRC_INIT, t[15:8]), t[7:0]);
    hc = crc8_shift(crc8_shift(hsfd_pkg::CRC_INIT, h[15:8]), h[7:0]);
    if (t_bad) tc ^= 8'($urandom_range(255, 1));
    if (h_bad) hc ^= 8'($urandom_range(255, 1));
    byte_queue.push_back('{t[15:8], marker});
    byte_queue.push_back('{t[7:0], 1'b0});
    byte_queue.push_back('{tc, 1'b0});
    byte_queue.push_back('{h[15:8], 1'b0});
    byte_queue.push_back('{h[7:0], 1'b0});
    byte_queue.push_back('{hc, 1'b0});
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Sender: predicts on each input transfer, then offers the next byte
  always @(posedge clk) begin
    bit           done;
    measurement_t meas;
    frame_byte_t  nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        decode_frame_byte(rx_byte, frame_start, done, meas);
        if (done) meas_queue.push_back(meas);
      end
      if (byte_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = byte_queue.pop_front();
        rx_byte     <= nxt.data;
        frame_start <= nxt.start;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure and field-by-field compare
  always @(posedge clk) begin
    measurement_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (meas_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: unexpected result t=%h h=%h", raw_temp, raw_humid);
        end else begin
          want = meas_queue.pop_front();
          if (raw_temp !== want.raw_temp || raw_humid !== want.raw_humid ||
              temp_crc_ok !== want.temp_ok || humid_crc_ok !== want.humid_ok ||
              temp_centi !== want.temp_centi || humid_centi !== want.humid_centi) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"ERROR: exp t=%h h=%h tok=%b hok=%b tc=%0d hc=%0d, ",
                        "got t=%h h=%h tok=%b hok=%b tc=%0d hc=%0d"},
                       want.raw_temp, want.raw_humid, want.temp_ok, want.humid_ok,
                       want.temp_centi, want.humid_centi, raw_temp, raw_humid,
                       temp_crc_ok, humid_crc_ok, temp_centi, humid_centi);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL humidity_sensor_frame_decoder_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus phases
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int added;
    int kind;
    int cut;
    idle_tab  = '{0, 66, 0, 27};
    stall_tab = '{0, 0, 66, 27};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_tab[ph];
      recv_stall_pct  = stall_tab[ph];
      if (ph == 0) begin
        // extremes, back to back without a marker, each flag cleared, restart mid-frame
        push_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        push_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        push_frame(16'hBEEF, 16'h1234, 1'b0, 1'b1, 1'b1);
        byte_queue.push_back('{8'hA5, 1'b1});
        byte_queue.push_back('{8'h5A, 1'b0});
        push_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
      end
      added = byte_queue.size();
      while (byte_queue.size() - added + (ph == 0 ? added : 0) < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          push_frame(pick_word(), pick_word(), 1'b0, 1'b0, $urandom_range(99) < 75);
        end else if (kind < 82) begin
          cut = $urandom_range(2, 0);
          push_frame(pick_word(), pick_word(), cut != 1, cut != 0, $urandom_range(99) < 75);
        end else if (kind < 92) begin
          // broken frame: a few leading bytes, then a marked frame
          cut = $urandom_range(5, 1);
          repeat (cut) byte_queue.push_back('{8'($urandom), 1'($urandom)});
          push_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1);
        end else begin
          cut = $urandom_range(4, 1);
          repeat (cut) byte_queue.push_back('{8'($urandom), 1'($urandom)});
        end
      end
      // sender holds off until the block has delivered every result
      while (!(byte_queue.size() == 0 && !in_valid && meas_queue.size() == 0))
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && meas_queue.size() == 0)
      $display("PASS humidity_sensor_frame_decoder_top");
    else
      $display("FAIL humidity_sensor_frame_decoder_top");
    $finish;
  end

endmodule
